// ===== rtl/pcc_pkg.sv =====
// Package for the pedestrian crossing controller: phase codes, register
// indexes, reset values and the seven-segment helpers.
// No dependencies; every other file in rtl uses it.
package pcc_pkg;

   typedef enum logic [1:0] {
      PH_WAIT  = 2'd0,
      PH_AMBER = 2'd1,
      PH_WALK  = 2'd2,
      PH_HOLD  = 2'd3
   } phase_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned TICKS_W     = 16;
   localparam int unsigned SECS_W      = 7;
   localparam int unsigned SEG_W       = 7;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [TICKS_W-1:0]     ticks_type;
   typedef logic [SECS_W-1:0]      secs_type;
   typedef logic [SEG_W-1:0]       seg_type;

   localparam csr_index_type REG_AMBER_TICKS      = 3'd0;
   localparam csr_index_type REG_WALK_SECONDS     = 3'd1;
   localparam csr_index_type REG_TICKS_PER_SECOND = 3'd2;
   localparam csr_index_type REG_BEEP_TICKS       = 3'd3;
   localparam csr_index_type REG_HOLD_GREEN_TICKS = 3'd4;

   localparam ticks_type RST_AMBER_TICKS      = 16'd2000;
   localparam secs_type  RST_WALK_SECONDS     = 7'd20;
   localparam ticks_type RST_TICKS_PER_SECOND = 16'd1000;
   localparam ticks_type RST_BEEP_TICKS       = 16'd250;
   localparam ticks_type RST_HOLD_GREEN_TICKS = 16'd20000;

   localparam ticks_type TICKS_MAX = '1;

   // Digit enables are active low: bit0 drives the tens digit.
   localparam logic [1:0] EN_TENS  = 2'b10;
   localparam logic [1:0] EN_UNITS = 2'b01;

   // Common-cathode pattern, bit0 is segment a; anything above nine is blank.
   function automatic seg_type seg_pattern(input logic [3:0] d);
      seg_type s;
      case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h67;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

   // Tens of a seven-bit value by a reciprocal multiply, exact below 1029.
   function automatic logic [3:0] tens_of(input secs_type v);
      logic [14:0] p;
      p = 15'(v) * 15'd205;
      return p[14:11];
   endfunction

   function automatic logic [3:0] units_of(input secs_type v);
      logic [3:0] t;
      secs_type   r;
      t = tens_of(v);
      r = v - SECS_W'(t) * 7'd10;
      return r[3:0];
   endfunction

endpackage

// ===== rtl/pcc_if.sv =====
// Handshake channels of the pedestrian crossing controller: the request
// word (tick, button, refresh) and the response word (lamps and display).
// Depends on pcc_pkg for the field types.
interface pcc_req_if;
   logic valid;
   logic ready;
   logic tick;
   logic button;
   logic refresh;

   modport source (output valid, output tick, output button, output refresh,
                   input ready);
   modport sink   (input valid, input tick, input button, input refresh,
                   output ready);
endinterface

interface pcc_rsp_if;
   logic             valid;
   logic             ready;
   logic             car_red;
   logic             car_amber;
   logic             car_green;
   logic             walk_red;
   logic             walk_green;
   logic             beeper_on;
   pcc_pkg::seg_type segments;
   logic [1:0]       digit_enables;
   logic [1:0]       phase;

   modport source (output valid, output car_red, output car_amber,
                   output car_green, output walk_red, output walk_green,
                   output beeper_on, output segments, output digit_enables,
                   output phase, input ready);
   modport sink   (input valid, input car_red, input car_amber,
                   input car_green, input walk_red, input walk_green,
                   input beeper_on, input segments, input digit_enables,
                   input phase, output ready);
endinterface

// ===== rtl/pedestrian_crossing_controller.sv =====
// Top level of the pedestrian crossing controller: phase sequencer, walk
// countdown, beeper and multiplexed two-digit display.
// Depends on pcc_pkg and the channel interfaces in pcc_if.sv.
//
// Each request word carries a tick flag, a button press and a display
// refresh strobe, and produces exactly one response word showing the lamps,
// beeper, display segments and phase after that word has been applied. The
// whole update is one pass through the phase counter logic into the state and
// response registers, so throughput is one word per cycle while the response
// side does not stall. The response register separates the two sides; a new
// word is taken whenever the response register is empty or its word is being
// taken in the same cycle. The user must write registers through the csr port
// only while the block is idle (not enforced); unknown indexes are ignored.
module pedestrian_crossing_controller (
   input  logic                   clock,
   input  logic                   reset,
   pcc_req_if.sink                req_ch,
   pcc_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  pcc_pkg::csr_index_type csr_index,
   input  pcc_pkg::csr_data_type  csr_wdata
);

   // Configuration registers.
   pcc_pkg::ticks_type amber_ticks_ff;
   pcc_pkg::secs_type  walk_seconds_ff;
   pcc_pkg::ticks_type ticks_per_second_ff;
   pcc_pkg::ticks_type beep_ticks_ff;
   pcc_pkg::ticks_type hold_green_ticks_ff;

   // Controller state.
   pcc_pkg::phase_type phase_ff, phase_in;
   pcc_pkg::ticks_type phase_ticks_ff, phase_ticks_in;
   pcc_pkg::secs_type  seconds_left_ff, seconds_left_in;
   pcc_pkg::secs_type  seconds_done_ff, seconds_done_in;
   logic               request_ff, request_in;
   logic               show_tens_ff, show_tens_in;

   // Response register.
   logic               rsp_valid_ff;
   logic               car_red_ff, car_amber_ff, car_green_ff;
   logic               walk_red_ff, walk_green_ff, beeper_ff;
   pcc_pkg::seg_type   segments_ff;
   logic [1:0]         digit_en_ff;

   logic               req_fire;
   pcc_pkg::ticks_type ticks_counted;
   pcc_pkg::secs_type  walk_len;
   pcc_pkg::secs_type  done_next;
   logic [3:0]         digit;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         amber_ticks_ff      <= pcc_pkg::RST_AMBER_TICKS;
         walk_seconds_ff     <= pcc_pkg::RST_WALK_SECONDS;
         ticks_per_second_ff <= pcc_pkg::RST_TICKS_PER_SECOND;
         beep_ticks_ff       <= pcc_pkg::RST_BEEP_TICKS;
         hold_green_ticks_ff <= pcc_pkg::RST_HOLD_GREEN_TICKS;
      end else if (csr_we) begin
         unique case (csr_index)
            pcc_pkg::REG_AMBER_TICKS:      amber_ticks_ff      <= csr_wdata;
            pcc_pkg::REG_WALK_SECONDS:     walk_seconds_ff     <= csr_wdata[6:0];
            pcc_pkg::REG_TICKS_PER_SECOND: ticks_per_second_ff <= csr_wdata;
            pcc_pkg::REG_BEEP_TICKS:       beep_ticks_ff       <= csr_wdata;
            pcc_pkg::REG_HOLD_GREEN_TICKS: hold_green_ticks_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign walk_len      = (walk_seconds_ff == '0) ? 7'd1 : walk_seconds_ff;
   assign ticks_counted = (req_ch.tick && phase_ticks_ff != pcc_pkg::TICKS_MAX)
                          ? phase_ticks_ff + 16'd1 : phase_ticks_ff;
   assign done_next     = seconds_done_ff + 7'd1;

   // Next state of the sequencer for the word being taken.
   always_comb begin
      phase_in        = phase_ff;
      phase_ticks_in  = phase_ticks_ff;
      seconds_left_in = seconds_left_ff;
      seconds_done_in = seconds_done_ff;
      request_in      = request_ff || req_ch.button;
      show_tens_in    = show_tens_ff ^ req_ch.refresh;
      unique case (phase_ff)
         pcc_pkg::PH_WAIT: begin
            if (request_in) begin
               phase_in       = pcc_pkg::PH_AMBER;
               phase_ticks_in = '0;
            end
         end
         pcc_pkg::PH_AMBER: begin
            phase_ticks_in = ticks_counted;
            if (ticks_counted >= amber_ticks_ff) begin
               phase_in        = pcc_pkg::PH_WALK;
               phase_ticks_in  = '0;
               seconds_done_in = '0;
               seconds_left_in = walk_len - 7'd1;
            end
         end
         pcc_pkg::PH_WALK: begin
            phase_ticks_in = ticks_counted;
            if (ticks_counted >= ticks_per_second_ff) begin
               phase_ticks_in  = '0;
               seconds_done_in = done_next;
               if (done_next >= walk_len) begin
                  // A press in the word that ends the walk is dropped too.
                  phase_in        = pcc_pkg::PH_HOLD;
                  request_in      = 1'b0;
                  seconds_left_in = '0;
               end else if (seconds_left_ff != '0) begin
                  seconds_left_in = seconds_left_ff - 7'd1;
               end
            end
         end
         pcc_pkg::PH_HOLD: begin
            phase_ticks_in = ticks_counted;
            if (ticks_counted >= hold_green_ticks_ff) begin
               phase_in       = pcc_pkg::PH_WAIT;
               phase_ticks_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= pcc_pkg::PH_WAIT;
         phase_ticks_ff  <= '0;
         seconds_left_ff <= '0;
         seconds_done_ff <= '0;
         request_ff      <= 1'b0;
         show_tens_ff    <= 1'b0;
      end else if (req_fire) begin
         phase_ff        <= phase_in;
         phase_ticks_ff  <= phase_ticks_in;
         seconds_left_ff <= seconds_left_in;
         seconds_done_ff <= seconds_done_in;
         request_ff      <= request_in;
         show_tens_ff    <= show_tens_in;
      end
   end

   assign digit = show_tens_in ? pcc_pkg::tens_of(seconds_left_in)
                               : pcc_pkg::units_of(seconds_left_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         car_red_ff    <= (phase_in == pcc_pkg::PH_WALK);
         car_amber_ff  <= (phase_in == pcc_pkg::PH_AMBER);
         car_green_ff  <= (phase_in == pcc_pkg::PH_WAIT) ||
                          (phase_in == pcc_pkg::PH_HOLD);
         walk_red_ff   <= (phase_in != pcc_pkg::PH_WALK);
         walk_green_ff <= (phase_in == pcc_pkg::PH_WALK);
         beeper_ff     <= (phase_in == pcc_pkg::PH_WALK) &&
                          (phase_ticks_in < beep_ticks_ff);
         segments_ff   <= pcc_pkg::seg_pattern(digit);
         digit_en_ff   <= show_tens_in ? pcc_pkg::EN_TENS : pcc_pkg::EN_UNITS;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.car_red       = car_red_ff;
   assign rsp_ch.car_amber     = car_amber_ff;
   assign rsp_ch.car_green     = car_green_ff;
   assign rsp_ch.walk_red      = walk_red_ff;
   assign rsp_ch.walk_green    = walk_green_ff;
   assign rsp_ch.beeper_on     = beeper_ff;
   assign rsp_ch.segments      = segments_ff;
   assign rsp_ch.digit_enables = digit_en_ff;
   assign rsp_ch.phase         = phase_ff;

`ifndef ASSERT_OFF
   a_leave_green: assert property (@(posedge clock) disable iff (reset)
      req_fire && phase_ff == pcc_pkg::PH_WAIT && (request_ff || req_ch.button)
      |=> phase_ff == pcc_pkg::PH_AMBER)
      else $error("green phase did not move to amber on a latched request");

   a_car_lamps: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> $onehot({rsp_ch.car_red, rsp_ch.car_amber, rsp_ch.car_green}))
      else $error("car lamps are not exactly one");

   a_beep_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.beeper_on |-> rsp_ch.phase == pcc_pkg::PH_WALK)
      else $error("beeper on outside the walk phase");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !req_fire |=> !rsp_ch.valid)
      else $error("response repeated after it was taken");

   a_walk_lamps: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.walk_green != rsp_ch.walk_red) &&
                       (rsp_ch.walk_green == rsp_ch.car_red))
      else $error("pedestrian lamps disagree with car lamps");
`endif

endmodule
